>>> sv/periodic_task_release_scheduler_core_defines.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_CORE_DEFINES_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTRS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ptrs_pkg.sv
// Types and constants of the periodic task release scheduler.
// No dependencies; imported by every scheduler module but ptrs_ram.
`default_nettype none

package ptrs_pkg;

    localparam int COUNT_W     = 9;
    localparam int SLOT_W      = 8;
    localparam int WORD_W      = 32;
    localparam int PERIOD_W    = 16;
    localparam int OFFSET_W    = 16;
    localparam int PERIOD_LSB  = 16;
    localparam int SLOT_REGS   = 4;
    localparam int SLOT_IDX_W  = 2;
    localparam int FIRE_W      = 4;
    localparam int REQ_W       = 2;
    localparam int CFG_INDEX_W = 3;

    // Remainder unit: two dividend bits per cycle over a zero-padded dividend.
    localparam int RADIX_BITS  = 2;
    localparam int MOD_STEPS   = (COUNT_W + RADIX_BITS - 1) / RADIX_BITS;
    localparam int DVD_W       = MOD_STEPS * RADIX_BITS;
    localparam int STEP_W      = 3;

    localparam logic [COUNT_W-1:0] CYCLE_LENGTH_RST = 9'd256;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 2'd0,
        REQ_RESTART = 2'd1,
        REQ_LOAD    = 2'd2
    } req_type_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CYCLE_START  = 3'd0,
        REG_CYCLE_LENGTH = 3'd1,
        REG_TASK0_SLOT   = 3'd2,
        REG_TASK1_SLOT   = 3'd3,
        REG_TASK2_SLOT   = 3'd4,
        REG_TASK3_SLOT   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [SLOT_W-1:0] table_index;
        logic [WORD_W-1:0] table_word;
    } ptrs_in_t;

    typedef struct packed {
        logic [FIRE_W-1:0] fire_mask;
        logic [WORD_W-1:0] activated_word;
        logic [SLOT_W-1:0] slot_used;
    } ptrs_out_t;

    typedef struct packed {
        logic                start;
        logic [COUNT_W-1:0]  dividend;
        logic [PERIOD_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } mod_rsp_t;

endpackage

`default_nettype wire

>>> sv/periodic_task_release_scheduler_core.sv
// Top level of the periodic task release scheduler.
// Depends on ptrs_pkg, ptrs_ram, ptrs_mod and the assertion macro header.
//
// Usage: items arrive on the s_ valid/ready channel; every item produces exactly
// one result transfer on the m_ valid/ready channel. A tick wraps the cycle
// counter when it has reached cycle_length, reads the activation word of that
// slot, evaluates the release condition of each task and advances the counter.
// A restart item reloads the counter from cycle_start; a load item writes one
// activation table word. Configuration registers are written over the cfg_
// channel, which is always ready; the user writes them only while the block is
// idle, and the block itself leaves this unenforced. Restart, load and unknown
// items return their result in the cycle after the transfer. A tick reads the
// table word in the fetch state, then for each task in turn launches it in the
// launch state, runs five steps of the shared remainder unit (two dividend bits
// each) and picks up its result in the wait state.
// One item is in flight at a time; the result sits in an output register, so
// the next item is taken as soon as that register is free or being drained.
// When the receiver stalls, the result is held and s_ready stays low.
// Reset clears the counter, configuration and latched word; the activation table
// reads as zero per entry until that entry is loaded, so no clearing pass runs.
`default_nettype none
`include "periodic_task_release_scheduler_core_defines.svh"

module periodic_task_release_scheduler_core #(
    parameter int NUM_TASKS   = 4,
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire ptrs_pkg::ptrs_in_t                   s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output ptrs_pkg::ptrs_out_t                       m_data,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ptrs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [ptrs_pkg::WORD_W-1:0]          cfg_data
);

    import ptrs_pkg::*;

    // Only table slots reachable by a load index can ever hold data.
    localparam int MEM_DEPTH    = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
    localparam int AW           = $clog2(MEM_DEPTH);
    localparam int ACTIVE_TASKS = (NUM_TASKS < SLOT_REGS) ? NUM_TASKS : SLOT_REGS;
    localparam logic [SLOT_IDX_W-1:0] LAST_TASK = SLOT_IDX_W'(ACTIVE_TASKS - 1);
    localparam logic [FIRE_W-1:0] ACTIVE_MASK = FIRE_W'((1 << ACTIVE_TASKS) - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FETCH  = 4'b0010,
        ST_LAUNCH = 4'b0100,
        ST_WAIT   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;

    // Configuration registers.
    logic [COUNT_W-1:0]  cycle_start_reg, cycle_start_next;
    logic [COUNT_W-1:0]  cycle_length_reg, cycle_length_next;
    logic [WORD_W-1:0]   slot_reg [SLOT_REGS];
    logic [WORD_W-1:0]   slot_next [SLOT_REGS];

    // Scheduler state.
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  count_used_reg, count_used_next;
    logic [WORD_W-1:0]   latched_reg, latched_next;
    logic [MEM_DEPTH-1:0] valid_reg, valid_next;
    logic                hit_reg, hit_next;
    logic [SLOT_IDX_W-1:0] task_idx_reg, task_idx_next;
    logic [FIRE_W-1:0]   fire_reg, fire_next;
    logic                enable_reg, enable_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    ptrs_out_t           m_data_reg, m_data_next;

    // Table and remainder unit hookup.
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [WORD_W-1:0]   mem_rdata;
    mod_req_t            mod_req;
    mod_rsp_t            mod_rsp;

    logic                in_xfer;
    logic [COUNT_W-1:0]  count_wrapped;
    logic                rd_in_range;
    logic                ld_in_range;
    logic [WORD_W-1:0]   cur_slot;
    logic [PERIOD_W-1:0] cur_period;
    logic [OFFSET_W-1:0] cur_offset;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_xfer   = s_valid && s_ready;

    // A counter at or past the cycle length (including a zero length) restarts at slot 0.
    assign count_wrapped = (count_reg >= cycle_length_reg) ? '0 : count_reg;
    assign rd_in_range   = (count_wrapped < COUNT_W'(MEM_DEPTH));
    assign ld_in_range   = ({1'b0, s_data.table_index} < COUNT_W'(MEM_DEPTH));

    assign cur_slot   = slot_reg[task_idx_reg];
    assign cur_period = cur_slot[PERIOD_LSB +: PERIOD_W];
    assign cur_offset = cur_slot[OFFSET_W-1:0];

    assign mem_we    = in_xfer && (s_data.req_type == REQ_LOAD) && ld_in_range;
    assign mem_waddr = s_data.table_index[AW-1:0];
    assign mem_re    = in_xfer && (s_data.req_type == REQ_TICK);
    assign mem_raddr = count_wrapped[AW-1:0];

    // A task is launched on the remainder unit even when it cannot fire; the
    // enable flag captured alongside masks the outcome.
    assign mod_req.start    = (state_reg == ST_LAUNCH);
    assign mod_req.dividend = count_used_reg - cur_offset[COUNT_W-1:0];
    assign mod_req.divisor  = cur_period;

    always_comb begin
        state_next        = state_reg;
        cycle_start_next  = cycle_start_reg;
        cycle_length_next = cycle_length_reg;
        slot_next         = slot_reg;
        count_next        = count_reg;
        count_used_next   = count_used_reg;
        latched_next      = latched_reg;
        valid_next        = valid_reg;
        hit_next          = hit_reg;
        task_idx_next     = task_idx_reg;
        fire_next         = fire_reg;
        enable_next       = enable_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_CYCLE_START:  cycle_start_next  = cfg_data[COUNT_W-1:0];
                REG_CYCLE_LENGTH: cycle_length_next = cfg_data[COUNT_W-1:0];
                REG_TASK0_SLOT:   slot_next[0]      = cfg_data;
                REG_TASK1_SLOT:   slot_next[1]      = cfg_data;
                REG_TASK2_SLOT:   slot_next[2]      = cfg_data;
                REG_TASK3_SLOT:   slot_next[3]      = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_data.req_type == REQ_TICK) begin
                        count_used_next = count_wrapped;
                        count_next      = count_wrapped + COUNT_W'(1);
                        hit_next        = rd_in_range && valid_reg[mem_raddr];
                        task_idx_next   = '0;
                        fire_next       = '0;
                        state_next      = ST_FETCH;
                    end else begin
                        // Restart, load and unknown items answer at once.
                        if (s_data.req_type == REQ_RESTART) begin
                            count_next = cycle_start_reg;
                        end
                        if (mem_we) begin
                            valid_next[mem_waddr] = 1'b1;
                        end
                        m_valid_next                = 1'b1;
                        m_data_next.fire_mask       = '0;
                        m_data_next.activated_word  = latched_reg;
                        m_data_next.slot_used       = '0;
                    end
                end
            end
            ST_FETCH: begin
                latched_next = hit_reg ? mem_rdata : '0;
                state_next   = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                enable_next = (cur_period != '0) &&
                              ({{(OFFSET_W-COUNT_W){1'b0}}, count_used_reg} >= cur_offset);
                state_next  = ST_WAIT;
            end
            ST_WAIT: begin
                if (mod_rsp.done) begin
                    fire_next[task_idx_reg] = enable_reg && mod_rsp.rem_zero;
                    if (task_idx_reg == LAST_TASK) begin
                        m_valid_next               = 1'b1;
                        m_data_next.fire_mask      = fire_next;
                        m_data_next.activated_word = latched_reg;
                        m_data_next.slot_used      = count_used_reg[SLOT_W-1:0];
                        state_next                 = ST_IDLE;
                    end else begin
                        task_idx_next = task_idx_reg + SLOT_IDX_W'(1);
                        state_next    = ST_LAUNCH;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cycle_start_reg  <= '0;
            cycle_length_reg <= CYCLE_LENGTH_RST;
            for (int i = 0; i < SLOT_REGS; i++) begin
                slot_reg[i] <= '0;
            end
            count_reg        <= '0;
            latched_reg      <= '0;
            valid_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cycle_start_reg  <= cycle_start_next;
            cycle_length_reg <= cycle_length_next;
            slot_reg         <= slot_next;
            count_reg        <= count_next;
            latched_reg      <= latched_next;
            valid_reg        <= valid_next;
            m_valid_reg      <= m_valid_next;
        end
        count_used_reg <= count_used_next;
        hit_reg        <= hit_next;
        task_idx_reg   <= task_idx_next;
        fire_reg       <= fire_next;
        enable_reg     <= enable_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ptrs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (s_data.table_word),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    ptrs_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (mod_req),
        .rsp_o   (mod_rsp)
    );

    `PTRS_ASSERT_NOW(a_fire_active_only, aclk, aresetn, m_valid_reg, (m_data_reg.fire_mask & ~ACTIVE_MASK) == '0, "fire bit of inactive task")
    `PTRS_ASSERT_NEXT(a_nontick_result, aclk, aresetn, in_xfer && (s_data.req_type != REQ_TICK), m_valid_reg && (m_data_reg.slot_used == '0), "non-tick result missing")
    `PTRS_ASSERT_NOW(a_mod_done_in_wait, aclk, aresetn, mod_rsp.done, state_reg == ST_WAIT, "remainder result outside wait")
    `PTRS_ASSERT_NEXT(a_tick_advance, aclk, aresetn, in_xfer && (s_data.req_type == REQ_TICK), count_reg == count_used_reg + COUNT_W'(1), "counter not advanced")

endmodule

`default_nettype wire

>>> sv/ptrs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module ptrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/ptrs_mod.sv
// Iterative remainder unit: dividend mod divisor, two bits per cycle.
// Depends on ptrs_pkg and the assertion macro header.
`default_nettype none
`include "periodic_task_release_scheduler_core_defines.svh"

module ptrs_mod (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ptrs_pkg::mod_req_t req_i,
    output ptrs_pkg::mod_rsp_t     rsp_o
);

    import ptrs_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [PERIOD_W-1:0] div_reg, div_next;

    logic [DVD_W-1:0]    dvd_work;
    logic [COUNT_W-1:0]  rem_work;

    // Restoring remainder steps; the partial remainder never exceeds the dividend.
    always_comb begin
        logic [COUNT_W:0] trial;
        rem_work = rem_reg;
        dvd_work = dvd_reg;
        for (int k = 0; k < RADIX_BITS; k++) begin
            trial    = {rem_work, dvd_work[DVD_W-1]};
            dvd_work = {dvd_work[DVD_W-2:0], 1'b0};
            if ({{(PERIOD_W-COUNT_W-1){1'b0}}, trial} >= div_reg) begin
                trial = trial - div_reg[COUNT_W:0];
            end
            rem_work = trial[COUNT_W-1:0];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req_i.start) begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = DVD_W'(req_i.dividend);
            rem_next  = '0;
            div_next  = req_i.divisor;
        end else if (busy_reg) begin
            dvd_next  = dvd_work;
            rem_next  = rem_work;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(MOD_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp_o.done     = done_reg;
    assign rsp_o.rem_zero = (rem_reg == '0);

    `PTRS_ASSERT_NOW(a_start_when_free, aclk, aresetn, req_i.start, !busy_reg, "start while busy")
    `PTRS_ASSERT_NEXT(a_done_single, aclk, aresetn, done_reg, !done_reg, "done held")
    `PTRS_ASSERT_NOW(a_step_range, aclk, aresetn, busy_reg, step_reg < STEP_W'(MOD_STEPS), "step overrun")

endmodule

`default_nettype wire

>>> tb/sv/ptrs_release_checker.sv
// Scoreboard for the periodic task release scheduler: tracks register writes and
// input transfers, predicts each result and compares it with the m_ channel.
// Depends on ptrs_pkg for the payload structs, request codes and register indexes.
`default_nettype none

module ptrs_release_checker
    import ptrs_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    input  wire logic                   s_ready,
    input  wire ptrs_in_t               s_data,
    input  wire logic                   m_valid,
    input  wire logic                   m_ready,
    input  wire ptrs_out_t              m_data,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]      cfg_data,
    output int                          mismatches,
    output int                          outstanding
);

    localparam int TABLE_ENTRIES = 256;

    logic [COUNT_W-1:0] start_value;
    logic [COUNT_W-1:0] wrap_length;
    logic [COUNT_W-1:0] tick_count;
    logic [WORD_W-1:0]  task_slot [SLOT_REGS];
    logic [WORD_W-1:0]  activation [TABLE_ENTRIES];
    logic [WORD_W-1:0]  held_word;
    ptrs_out_t          expected_releases [$];
    int                 error_total = 0;

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        error_total++;
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic bit task_due(input logic [WORD_W-1:0] slot,
                                    input logic [COUNT_W-1:0] count);
        int unsigned period;
        int unsigned offset;
        int unsigned cnt;
        period = 32'(slot[WORD_W-1:PERIOD_LSB]);
        offset = 32'(slot[OFFSET_W-1:0]);
        cnt    = 32'(count);
        if (slot == '0 || cnt < offset || period == 0)
            return 1'b0;
        return ((cnt - offset) % period) == 0;
    endfunction

    task automatic predict_release(input ptrs_in_t req, output ptrs_out_t res);
        res = '0;
        case (req.req_type)
            REQ_TICK: begin
                if (tick_count >= wrap_length)
                    tick_count = '0;
                held_word = (tick_count < TABLE_ENTRIES) ? activation[tick_count[SLOT_W-1:0]]
                                                         : '0;
                for (int t = 0; t < SLOT_REGS; t++)
                    if (task_due(task_slot[t], tick_count))
                        res.fire_mask[t] = 1'b1;
                res.slot_used = tick_count[SLOT_W-1:0];
                tick_count = tick_count + COUNT_W'(1);
            end
            REQ_RESTART: tick_count = start_value;
            REQ_LOAD:    activation[req.table_index] = req.table_word;
            default: ;
        endcase
        res.activated_word = held_word;
    endtask

    always @(posedge aclk) begin
        ptrs_out_t want;
        ptrs_out_t fresh;
        if (!aresetn) begin
            start_value = '0;
            wrap_length = CYCLE_LENGTH_RST;
            tick_count  = '0;
            held_word   = '0;
            for (int t = 0; t < SLOT_REGS; t++)
                task_slot[t] = '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                activation[i] = '0;
            expected_releases.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CYCLE_START:  start_value  = cfg_data[COUNT_W-1:0];
                    REG_CYCLE_LENGTH: wrap_length  = cfg_data[COUNT_W-1:0];
                    REG_TASK0_SLOT:   task_slot[0] = cfg_data;
                    REG_TASK1_SLOT:   task_slot[1] = cfg_data;
                    REG_TASK2_SLOT:   task_slot[2] = cfg_data;
                    REG_TASK3_SLOT:   task_slot[3] = cfg_data;
                    default: ;
                endcase
            end
            // Results are compared before the new item is queued; a result can
            // never belong to an item accepted at the same edge.
            if (m_valid && m_ready) begin
                if (expected_releases.size() == 0) begin
                    report_mismatch("result with no item outstanding", m_data.activated_word, '0);
                end else begin
                    want = expected_releases.pop_front();
                    if (m_data.fire_mask !== want.fire_mask)
                        report_mismatch("fire_mask", WORD_W'(m_data.fire_mask),
                                        WORD_W'(want.fire_mask));
                    if (m_data.activated_word !== want.activated_word)
                        report_mismatch("activated_word", m_data.activated_word,
                                        want.activated_word);
                    if (m_data.slot_used !== want.slot_used)
                        report_mismatch("slot_used", WORD_W'(m_data.slot_used),
                                        WORD_W'(want.slot_used));
                end
            end
            if (s_valid && s_ready) begin
                predict_release(s_data, fresh);
                expected_releases.push_back(fresh);
            end
        end
        mismatches  <= error_total;
        outstanding <= expected_releases.size();
    end

endmodule

`default_nettype wire

>>> tb/sv/periodic_task_release_scheduler_core_tb.sv
// Top of the scheduler testbench: clock, reset, stimulus and the verdict.
// Depends on ptrs_pkg, the scheduler core and ptrs_release_checker.
`default_nettype none

module periodic_task_release_scheduler_core_tb;
    import ptrs_pkg::*;

    // Codes that the package leaves unnamed: a request type the block must
    // ignore and a register index with no register behind it.
    localparam logic [REQ_W-1:0]       REQ_UNKNOWN  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 125;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    ptrs_in_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    ptrs_out_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_data  = '0;

    int mismatches;
    int outstanding;
    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;
    int sink_wait = 0;

    periodic_task_release_scheduler_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ptrs_release_checker scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The slowest legal run adds up a sender gap, a full tick through the remainder
    // unit and a receiver stall for each item, so this limit is several times
    // what 1000 items and the phase changes can take.
    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: after every transfer the receiver draws a random stall, then
    // keeps ready high until the next transfer. Some phases run with stalls
    // switched off so that back-to-back results also occur.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait <= 0;
        end else if (m_valid && m_ready) begin
            int stall;
            stall = stall_on ? $urandom_range(0, 5) : 0;
            sink_wait <= stall;
            m_ready   <= (stall == 0);
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_ready   <= (sink_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // One register write transfer. Valid is left high so that consecutive
    // writes go back to back; the caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Writes every register, plus an unmapped index that must be ignored.
    // Only called while nothing is in flight.
    task automatic configure(input logic [WORD_W-1:0] start_word,
                             input logic [WORD_W-1:0] length_word,
                             input logic [WORD_W-1:0] t0, input logic [WORD_W-1:0] t1,
                             input logic [WORD_W-1:0] t2, input logic [WORD_W-1:0] t3);
        write_reg(REG_CYCLE_START, start_word);
        write_reg(REG_CYCLE_LENGTH, length_word);
        write_reg(REG_TASK0_SLOT, t0);
        write_reg(REG_TASK1_SLOT, t1);
        write_reg(REG_TASK2_SLOT, t2);
        write_reg(REG_TASK3_SLOT, t3);
        write_reg(REG_UNMAPPED, $urandom());
        cfg_valid <= 1'b0;
    endtask

    // One input transfer after a random gap. Valid is only lowered when a gap
    // follows, so it never drops and rises again within one time step.
    task automatic send_item(input ptrs_in_t item);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] idx,
                        input logic [WORD_W-1:0] word);
        ptrs_in_t item;
        item.req_type    = req;
        item.table_index = idx;
        item.table_word  = word;
        send_item(item);
    endtask

    // Holds the sender off until every outstanding result has been transferred,
    // then keeps waiting so the block is idle for register writes.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Random slot register: mostly short periods and small offsets so that
    // releases actually happen, plus disabled tasks, zero periods with an
    // offset, the longest period and arbitrary words.
    function automatic logic [WORD_W-1:0] draw_slot();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return {16'h0000, 16'($urandom_range(1, 40))};
            2: return $urandom();
            3: return {16'hFFFF, 16'($urandom_range(0, 20))};
            default: return {16'($urandom_range(1, 12)), 16'($urandom_range(0, 15))};
        endcase
    endfunction

    initial begin
        ptrs_in_t           item;
        int                 pick;
        logic [COUNT_W-1:0] start_val;
        logic [COUNT_W-1:0] length_val;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Start register written with all ones (reads back as
        // 511); task 0 fires every tick, task 1 has a zero period with an
        // offset and must never fire, task 2 has the largest period and
        // offset, task 3 fires every third tick from slot 2.
        configure(32'hFFFF_FFFF, 32'd256, 32'h0001_0000, 32'h0000_0003,
                  32'hFFFF_FFFF, 32'h0003_0002);
        send(REQ_LOAD, 8'd0,   32'hFFFF_FFFF);
        send(REQ_LOAD, 8'd255, 32'h0000_0000);
        send(REQ_LOAD, 8'd255, 32'hFFFF_FFFF);
        send(REQ_LOAD, 8'd1,   32'hA5A5_5A5A);
        send(REQ_LOAD, 8'd2,   32'h5A5A_A5A5);
        send(REQ_LOAD, 8'd3,   32'h0000_0000);
        repeat (4) send(REQ_TICK, 8'($urandom()), $urandom());
        send(REQ_UNKNOWN, 8'hFF, $urandom());
        // A restart loads 511, which is past the cycle length: the tick wraps.
        send(REQ_RESTART, 8'h00, 32'h0);
        send(REQ_TICK, 8'h00, 32'h0);
        drain();

        // Zero cycle length: every tick wraps to slot zero first.
        configure(32'd300, 32'd0, 32'h0001_0000, 32'h0000_0003,
                  32'hFFFF_FFFF, 32'h0003_0002);
        send(REQ_TICK, 8'h00, 32'h0);
        send(REQ_TICK, 8'h00, 32'h0);
        drain();

        // Counter past the end of the table: the tick latches a zero word.
        configure(32'd300, 32'd511, 32'h0001_0000, 32'h0000_0003,
                  32'hFFFF_FFFF, 32'h0003_0002);
        send(REQ_RESTART, 8'h00, 32'h0);
        send(REQ_TICK, 8'h00, 32'h0);
        send(REQ_TICK, 8'h00, 32'h0);
        drain();

        // Random part. The first six phases pin the start and length registers, several
        // to their extremes; the rest draw them freely. Upper register bits are
        // random so the block has to ignore them.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin start_val = 9'd0;   length_val = 9'd256; end
                1: begin start_val = 9'd511; length_val = 9'd1;   end
                2: begin start_val = 9'd256; length_val = 9'd511; end
                3: begin start_val = 9'd0;   length_val = 9'd0;   end
                4: begin start_val = 9'd2;   length_val = 9'd3;   end
                5: begin start_val = 9'd290; length_val = 9'd300; end
                default: begin
                    start_val  = 9'($urandom_range(0, 511));
                    length_val = 9'($urandom_range(0, 511));
                end
            endcase
            gaps_on  = (p % 3 != 1);
            stall_on <= (p % 4 != 2);
            configure({23'($urandom()), start_val}, {23'($urandom()), length_val},
                      draw_slot(), draw_slot(), draw_slot(), draw_slot());

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Half the loads target low slots so that short cycles pick
                // up freshly written words.
                item.table_index = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                               : 8'($urandom_range(0, 255));
                item.table_word  = ($urandom_range(0, 15) == 0) ? '0 : $urandom();
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    item.req_type = REQ_TICK;
                else if (pick < 70)
                    item.req_type = REQ_RESTART;
                else if (pick < 95)
                    item.req_type = REQ_LOAD;
                else
                    item.req_type = REQ_UNKNOWN;
                send_item(item);
                // Mid-phase pause: the sender waits for the block to empty.
                if (p == 4 && n == ITEMS_PER_PHASE / 2)
                    drain();
            end
            drain();
        end

        repeat (40) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
